// File: sv/assert_macros.svh
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: invariant");

`else

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`define ASSERT_ALWAYS(label, clk, rst, expr)

`endif

`endif

// File: sv/pfc_pkg.sv
`timescale 1ns / 1ps

package pfc_pkg;

   localparam int PixelWidth = 48;
   localparam int ChanWidth  = 16;

   // pixel_format register codes
   localparam logic [3:0] FMT_EPAPER  = 4'd0;
   localparam logic [3:0] FMT_GREY1   = 4'd1;
   localparam logic [3:0] FMT_GREY2   = 4'd2;
   localparam logic [3:0] FMT_GREY4   = 4'd3;
   localparam logic [3:0] FMT_GREY8   = 4'd4;
   localparam logic [3:0] FMT_GREY16  = 4'd5;
   localparam logic [3:0] FMT_RGB332  = 4'd6;
   localparam logic [3:0] FMT_RGB565  = 4'd7;
   localparam logic [3:0] FMT_RGB666  = 4'd8;
   localparam logic [3:0] FMT_RGB888  = 4'd9;
   localparam logic [3:0] FMT_RGB30   = 4'd10;
   localparam logic [3:0] FMT_RGB36   = 4'd11;
   localparam logic [3:0] FMT_RGB48   = 4'd12;

   // action codes
   localparam logic [2:0] ACT_RGB48_TO_RAW  = 3'd0;
   localparam logic [2:0] ACT_RAW_TO_RGB48  = 3'd1;
   localparam logic [2:0] ACT_GREY16_TO_RAW = 3'd2;
   localparam logic [2:0] ACT_RAW_TO_GREY16 = 3'd3;
   localparam logic [2:0] ACT_RGB24_TO_RAW  = 3'd4;
   localparam logic [2:0] ACT_RAW_TO_RGB24  = 3'd5;

   // e-paper raw codes
   localparam logic [1:0] EPD_WHITE = 2'b00;
   localparam logic [1:0] EPD_BLACK = 2'b01;
   localparam logic [1:0] EPD_RED   = 2'b10;

   localparam logic [15:0] EPD_GREY_BLACK_LIM = 16'h2000;
   localparam logic [15:0] EPD_GREY_RED_LIM   = 16'h8000;
   localparam logic [15:0] EPD_RGB_BLACK_LIM  = 16'd256;
   localparam logic [15:0] EPD_RED_GREY16     = 16'h3fff;

   // floor(x / 3) = (x * DIV3_RECIP) >> DIV3_SHIFT for x < 2**19
   localparam logic [17:0] DIV3_RECIP = 18'h2aaab;
   localparam int          DIV3_SHIFT = 19;

   typedef struct packed {
      logic [ChanWidth-1:0] r;
      logic [ChanWidth-1:0] g;
      logic [ChanWidth-1:0] b;
   } rgb_type;

endpackage

// File: sv/pfc_unpack.sv
`timescale 1ns / 1ps

module pfc_unpack (
   input  logic [3:0]                        fmt,
   input  logic [pfc_pkg::PixelWidth-1:0]    raw,
   output pfc_pkg::rgb_type                  rgb
);

   always_comb begin
      rgb = '0;
      case (fmt)
         pfc_pkg::FMT_EPAPER: begin
            if (raw[0]) begin
               rgb = '0;
            end else if (raw[1]) begin
               rgb.r = 16'hffff;
            end else begin
               rgb = '1;
            end
         end
         pfc_pkg::FMT_GREY1: begin
            rgb.r = {16{raw[0]}};
            rgb.g = rgb.r;
            rgb.b = rgb.r;
         end
         pfc_pkg::FMT_GREY2: begin
            rgb.r = {8{raw[1:0]}};
            rgb.g = rgb.r;
            rgb.b = rgb.r;
         end
         pfc_pkg::FMT_GREY4: begin
            rgb.r = {4{raw[3:0]}};
            rgb.g = rgb.r;
            rgb.b = rgb.r;
         end
         pfc_pkg::FMT_GREY8: begin
            rgb.r = {2{raw[7:0]}};
            rgb.g = rgb.r;
            rgb.b = rgb.r;
         end
         pfc_pkg::FMT_GREY16: begin
            rgb.r = raw[15:0];
            rgb.g = rgb.r;
            rgb.b = rgb.r;
         end
         pfc_pkg::FMT_RGB332: begin
            rgb.r = {raw[7:5], raw[7:5], raw[7:5], raw[7:5], raw[7:5], raw[7]};
            rgb.g = {raw[4:2], raw[4:2], raw[4:2], raw[4:2], raw[4:2], raw[4]};
            rgb.b = {8{raw[1:0]}};
         end
         pfc_pkg::FMT_RGB565: begin
            rgb.r = {raw[15:11], raw[15:11], raw[15:11], raw[15]};
            rgb.g = {raw[10:5], raw[10:5], raw[10:7]};
            rgb.b = {raw[4:0], raw[4:0], raw[4:0], raw[4]};
         end
         pfc_pkg::FMT_RGB666: begin
            rgb.r = {raw[17:12], raw[17:12], raw[17:14]};
            rgb.g = {raw[11:6], raw[11:6], raw[11:8]};
            rgb.b = {raw[5:0], raw[5:0], raw[5:2]};
         end
         pfc_pkg::FMT_RGB30: begin
            rgb.r = {raw[29:20], raw[29:24]};
            rgb.g = {raw[19:10], raw[19:14]};
            rgb.b = {raw[9:0], raw[9:4]};
         end
         pfc_pkg::FMT_RGB36: begin
            rgb.r = {raw[35:24], raw[35:32]};
            rgb.g = {raw[23:12], raw[23:20]};
            rgb.b = {raw[11:0], raw[11:8]};
         end
         pfc_pkg::FMT_RGB48: begin
            rgb.r = raw[47:32];
            rgb.g = raw[31:16];
            rgb.b = raw[15:0];
         end
         default: begin
            rgb.r = {2{raw[23:16]}};
            rgb.g = {2{raw[15:8]}};
            rgb.b = {2{raw[7:0]}};
         end
      endcase
   end

endmodule

// File: sv/pfc_div3.sv
`timescale 1ns / 1ps

module pfc_div3 (
   input  pfc_pkg::rgb_type                  rgb,
   output logic [pfc_pkg::ChanWidth-1:0]     mean
);

   logic [17:0] sum;
   logic [35:0] prod;

   assign sum  = {2'b00, rgb.r} + {2'b00, rgb.g} + {2'b00, rgb.b};
   assign prod = {18'd0, sum} * {18'd0, pfc_pkg::DIV3_RECIP};
   assign mean = prod[pfc_pkg::DIV3_SHIFT +: pfc_pkg::ChanWidth];

endmodule

// File: sv/pfc_pack.sv
`timescale 1ns / 1ps

module pfc_pack (
   input  logic [3:0]                        fmt,
   input  pfc_pkg::rgb_type                  rgb,
   input  logic [pfc_pkg::ChanWidth-1:0]     mean,
   input  logic                              from_grey,
   output logic [pfc_pkg::PixelWidth-1:0]    raw
);

   logic [1:0] epd;

   always_comb begin
      if (from_grey) begin
         if (mean < pfc_pkg::EPD_GREY_BLACK_LIM) begin
            epd = pfc_pkg::EPD_BLACK;
         end else if (mean < pfc_pkg::EPD_GREY_RED_LIM) begin
            epd = pfc_pkg::EPD_RED;
         end else begin
            epd = pfc_pkg::EPD_WHITE;
         end
      end else begin
         if (mean < pfc_pkg::EPD_RGB_BLACK_LIM) begin
            epd = pfc_pkg::EPD_BLACK;
         end else if (rgb.r > mean) begin
            epd = pfc_pkg::EPD_RED;
         end else begin
            epd = pfc_pkg::EPD_WHITE;
         end
      end
   end

   always_comb begin
      case (fmt)
         pfc_pkg::FMT_EPAPER: raw = {46'd0, epd};
         pfc_pkg::FMT_GREY1:  raw = {47'd0, mean[15]};
         pfc_pkg::FMT_GREY2:  raw = {46'd0, mean[15:14]};
         pfc_pkg::FMT_GREY4:  raw = {44'd0, mean[15:12]};
         pfc_pkg::FMT_GREY8:  raw = {40'd0, mean[15:8]};
         pfc_pkg::FMT_GREY16: raw = {32'd0, mean};
         pfc_pkg::FMT_RGB332: raw = {40'd0, rgb.r[15:13], rgb.g[15:13], rgb.b[15:14]};
         pfc_pkg::FMT_RGB565: raw = {32'd0, rgb.r[15:11], rgb.g[15:10], rgb.b[15:11]};
         pfc_pkg::FMT_RGB666: raw = {30'd0, rgb.r[15:10], rgb.g[15:10], rgb.b[15:10]};
         pfc_pkg::FMT_RGB30:  raw = {18'd0, rgb.r[15:6], rgb.g[15:6], rgb.b[15:6]};
         pfc_pkg::FMT_RGB36:  raw = {12'd0, rgb.r[15:4], rgb.g[15:4], rgb.b[15:4]};
         pfc_pkg::FMT_RGB48:  raw = {rgb.r, rgb.g, rgb.b};
         default:             raw = {24'd0, rgb.r[15:8], rgb.g[15:8], rgb.b[15:8]};
      endcase
   end

endmodule

// File: sv/pixel_format_converter_core.sv
`timescale 1ns / 1ps
// Pixel format converter, one pixel per clock.
// Request: req_action and req_pixel_in are taken at a rising edge where start
// is high and busy is low. busy stays low, so a new transaction can be issued
// every cycle.
// Response: rsp_pixel_out is shown for exactly one cycle with rsp_valid high.
// A transaction taken is captured in the input register, converted in one pass
// of combinational logic and loaded into the result register; rsp_valid and
// rsp_pixel_out are driven straight from the result register stage.
// Throughput is one transaction per cycle; there is no backpressure on the
// response side, the receiver must take every strobe.
// Config: csr_we with csr_wdata writes pixel_format; write it only while no
// transaction is in flight. The new format applies to the next transaction.
// Reset (synchronous, active high) drops any transaction in flight and sets
// pixel_format to RGB888.
`include "assert_macros.svh"

module pixel_format_converter_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [2:0]                        req_action,
   input  logic [pfc_pkg::PixelWidth-1:0]    req_pixel_in,
   input  logic                              csr_we,
   input  logic [3:0]                        csr_wdata,
   output logic                              rsp_valid,
   output logic [pfc_pkg::PixelWidth-1:0]    rsp_pixel_out
);

   logic                              is_epaper;
   logic [3:0]                        format_ff;
   logic                              in_valid_ff;
   logic [2:0]                        in_action_ff;
   logic [pfc_pkg::PixelWidth-1:0]    in_pixel_ff;
   logic                              out_valid_ff;
   logic [pfc_pkg::PixelWidth-1:0]    out_pixel_ff;
   logic [pfc_pkg::PixelWidth-1:0]    out_pixel_in;

   pfc_pkg::rgb_type                  unp_rgb;
   pfc_pkg::rgb_type                  src_rgb;
   logic [pfc_pkg::ChanWidth-1:0]     mean;
   logic [pfc_pkg::PixelWidth-1:0]    packed_raw;
   logic [pfc_pkg::ChanWidth-1:0]     epd_grey;
   logic                              from_grey;

   assign busy = 1'b0;
   assign is_epaper = (format_ff == pfc_pkg::FMT_EPAPER);

   pfc_unpack u_unpack (
      .fmt (format_ff),
      .raw (in_pixel_ff),
      .rgb (unp_rgb)
   );

   always_comb begin
      case (in_action_ff)
         pfc_pkg::ACT_RGB48_TO_RAW: begin
            src_rgb.r = in_pixel_ff[47:32];
            src_rgb.g = in_pixel_ff[31:16];
            src_rgb.b = in_pixel_ff[15:0];
         end
         pfc_pkg::ACT_GREY16_TO_RAW: begin
            src_rgb.r = in_pixel_ff[15:0];
            src_rgb.g = in_pixel_ff[15:0];
            src_rgb.b = in_pixel_ff[15:0];
         end
         pfc_pkg::ACT_RGB24_TO_RAW: begin
            src_rgb.r = {2{in_pixel_ff[23:16]}};
            src_rgb.g = {2{in_pixel_ff[15:8]}};
            src_rgb.b = {2{in_pixel_ff[7:0]}};
         end
         default: src_rgb = unp_rgb;
      endcase
   end

   pfc_div3 u_div3 (
      .rgb  (src_rgb),
      .mean (mean)
   );

   assign from_grey = (in_action_ff == pfc_pkg::ACT_GREY16_TO_RAW);

   pfc_pack u_pack (
      .fmt       (format_ff),
      .rgb       (src_rgb),
      .mean      (mean),
      .from_grey (from_grey),
      .raw       (packed_raw)
   );

   always_comb begin
      if (in_pixel_ff[0]) begin
         epd_grey = '0;
      end else if (in_pixel_ff[1]) begin
         epd_grey = pfc_pkg::EPD_RED_GREY16;
      end else begin
         epd_grey = '1;
      end
   end

   always_comb begin
      case (in_action_ff)
         pfc_pkg::ACT_RGB48_TO_RAW,
         pfc_pkg::ACT_GREY16_TO_RAW,
         pfc_pkg::ACT_RGB24_TO_RAW:  out_pixel_in = packed_raw;
         pfc_pkg::ACT_RAW_TO_RGB48:  out_pixel_in = {unp_rgb.r, unp_rgb.g, unp_rgb.b};
         pfc_pkg::ACT_RAW_TO_GREY16: out_pixel_in = {32'd0, is_epaper ? epd_grey : mean};
         pfc_pkg::ACT_RAW_TO_RGB24:
            out_pixel_in = {24'd0, unp_rgb.r[15:8], unp_rgb.g[15:8], unp_rgb.b[15:8]};
         default:                    out_pixel_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff    <= pfc_pkg::FMT_RGB888;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            format_ff <= csr_wdata;
         end
         in_valid_ff  <= start && !busy;
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         in_action_ff <= req_action;
         in_pixel_ff  <= req_pixel_in;
      end
      out_pixel_ff <= out_pixel_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_pixel_out = out_pixel_ff;

   `ASSERT_NEXT(a_valid_follows, clock, reset, in_valid_ff, out_valid_ff)
   `ASSERT_NEXT(a_no_spurious, clock, reset, !in_valid_ff, !out_valid_ff)
   `ASSERT_NEXT(a_bad_action_zero, clock, reset,
                in_valid_ff && in_action_ff > pfc_pkg::ACT_RAW_TO_RGB24,
                out_pixel_ff == '0)
   `ASSERT_NEXT(a_rgb24_width, clock, reset,
                in_valid_ff && in_action_ff == pfc_pkg::ACT_RAW_TO_RGB24,
                out_pixel_ff[47:24] == '0)
   `ASSERT_NEXT(a_grey16_width, clock, reset,
                in_valid_ff && in_action_ff == pfc_pkg::ACT_RAW_TO_GREY16,
                out_pixel_ff[47:16] == '0)

endmodule

// File: tb/tb_pixel_format_converter_core.sv
`timescale 1ns / 1ps

module tb_pixel_format_converter_core;

   localparam logic [2:0] ACT_SPARE_LO = 3'd6;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;
   localparam logic [3:0] FMT_SPARE_HI = 4'd15;
   localparam int         PHASES       = 32;
   localparam int         PHASE_PIXELS = 53;

   typedef struct packed {
      logic                           is_cfg;
      logic [3:0]                     fmt;
      logic [2:0]                     action;
      logic [pfc_pkg::PixelWidth-1:0] pixel;
      logic [3:0]                     gap;
   } pixel_job_type;

   logic                           clock        = 1'b0;
   logic                           reset        = 1'b1;
   logic                           start        = 1'b0;
   logic                           busy;
   logic [2:0]                     req_action   = '0;
   logic [pfc_pkg::PixelWidth-1:0] req_pixel_in = '0;
   logic                           csr_we       = 1'b0;
   logic [3:0]                     csr_wdata    = '0;
   logic                           rsp_valid;
   logic [pfc_pkg::PixelWidth-1:0] rsp_pixel_out;

   pixel_job_type                  job_q[$];
   logic [pfc_pkg::PixelWidth-1:0] expected_pixels[$];
   pixel_job_type                  cur_job;
   logic                           have_job     = 1'b0;
   logic                           in_flight    = 1'b0;
   logic                           drv_start;
   logic                           drv_we;
   logic [3:0]                     fmt_model    = pfc_pkg::FMT_RGB888;
   int                             n_issued     = 0;
   int                             n_accepted   = 0;
   int                             n_checked    = 0;
   int                             n_fmt_writes = 0;
   int                             n_errors     = 0;

   pixel_format_converter_core i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_action    (req_action),
      .req_pixel_in  (req_pixel_in),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_pixel_out (rsp_pixel_out)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [15:0] widen(logic [31:0] x, logic [31:0] k, int sh);
      logic [31:0] t;
      t = (x * k) >> sh;
      return t[15:0];
   endfunction

   function automatic logic [pfc_pkg::PixelWidth-1:0] pack_rgb(logic [3:0] fmt,
                                                               logic [15:0] r,
                                                               logic [15:0] g,
                                                               logic [15:0] b,
                                                               logic from_grey);
      logic [17:0]                    sum;
      logic [15:0]                    v;
      logic [pfc_pkg::PixelWidth-1:0] res;
      sum = {2'b00, r} + {2'b00, g} + {2'b00, b};
      v   = 16'(sum / 3);
      res = '0;
      case (fmt)
         pfc_pkg::FMT_EPAPER: begin
            if (from_grey) begin
               if (v < pfc_pkg::EPD_GREY_BLACK_LIM) res = {46'd0, pfc_pkg::EPD_BLACK};
               else if (v < pfc_pkg::EPD_GREY_RED_LIM) res = {46'd0, pfc_pkg::EPD_RED};
               else res = {46'd0, pfc_pkg::EPD_WHITE};
            end else begin
               if (v < pfc_pkg::EPD_RGB_BLACK_LIM) res = {46'd0, pfc_pkg::EPD_BLACK};
               else if (r > v) res = {46'd0, pfc_pkg::EPD_RED};
               else res = {46'd0, pfc_pkg::EPD_WHITE};
            end
         end
         pfc_pkg::FMT_GREY1:  res = {47'd0, v[15]};
         pfc_pkg::FMT_GREY2:  res = {46'd0, v[15:14]};
         pfc_pkg::FMT_GREY4:  res = {44'd0, v[15:12]};
         pfc_pkg::FMT_GREY8:  res = {40'd0, v[15:8]};
         pfc_pkg::FMT_GREY16: res = {32'd0, v};
         pfc_pkg::FMT_RGB332: res = {40'd0, r[15:13], g[15:13], b[15:14]};
         pfc_pkg::FMT_RGB565: res = {32'd0, r[15:11], g[15:10], b[15:11]};
         pfc_pkg::FMT_RGB666: res = {30'd0, r[15:10], g[15:10], b[15:10]};
         pfc_pkg::FMT_RGB30:  res = {18'd0, r[15:6], g[15:6], b[15:6]};
         pfc_pkg::FMT_RGB36:  res = {12'd0, r[15:4], g[15:4], b[15:4]};
         pfc_pkg::FMT_RGB48:  res = {r, g, b};
         default:             res = {24'd0, r[15:8], g[15:8], b[15:8]};
      endcase
      return res;
   endfunction

   function automatic pfc_pkg::rgb_type unpack_raw(logic [3:0] fmt,
                                                   logic [pfc_pkg::PixelWidth-1:0] raw);
      pfc_pkg::rgb_type c;
      logic [15:0]      v;
      v = '0;
      c = '0;
      case (fmt)
         pfc_pkg::FMT_EPAPER: begin
            if (raw[0]) c = '0;
            else if (raw[1]) c = '{r: 16'hffff, g: 16'h0000, b: 16'h0000};
            else c = '{r: 16'hffff, g: 16'hffff, b: 16'hffff};
         end
         pfc_pkg::FMT_GREY1:  v = {16{raw[0]}};
         pfc_pkg::FMT_GREY2:  v = {8{raw[1:0]}};
         pfc_pkg::FMT_GREY4:  v = {4{raw[3:0]}};
         pfc_pkg::FMT_GREY8:  v = {2{raw[7:0]}};
         pfc_pkg::FMT_GREY16: v = raw[15:0];
         pfc_pkg::FMT_RGB332: begin
            c.r = widen(32'(raw[7:5]), 32'h9249, 2);
            c.g = widen(32'(raw[4:2]), 32'h9249, 2);
            c.b = widen(32'(raw[1:0]), 32'h5555, 0);
         end
         pfc_pkg::FMT_RGB565: begin
            c.r = widen(32'(raw[15:11]), 32'h8421, 4);
            c.g = widen(32'(raw[10:5]), 32'h1041, 2);
            c.b = widen(32'(raw[4:0]), 32'h8421, 4);
         end
         pfc_pkg::FMT_RGB666: begin
            c.r = widen(32'(raw[17:12]), 32'h1041, 2);
            c.g = widen(32'(raw[11:6]), 32'h1041, 2);
            c.b = widen(32'(raw[5:0]), 32'h1041, 2);
         end
         pfc_pkg::FMT_RGB30: begin
            c.r = widen(32'(raw[29:20]), 32'h0401, 4);
            c.g = widen(32'(raw[19:10]), 32'h0401, 4);
            c.b = widen(32'(raw[9:0]), 32'h0401, 4);
         end
         pfc_pkg::FMT_RGB36: begin
            c.r = widen(32'(raw[35:24]), 32'h1001, 8);
            c.g = widen(32'(raw[23:12]), 32'h1001, 8);
            c.b = widen(32'(raw[11:0]), 32'h1001, 8);
         end
         pfc_pkg::FMT_RGB48: c = raw;
         default: c = '{r: {2{raw[23:16]}}, g: {2{raw[15:8]}}, b: {2{raw[7:0]}}};
      endcase
      if (fmt inside {[pfc_pkg::FMT_GREY1:pfc_pkg::FMT_GREY16]}) c = '{r: v, g: v, b: v};
      return c;
   endfunction

   function automatic logic [pfc_pkg::PixelWidth-1:0] convert_pixel(
         logic [3:0] fmt, logic [2:0] action, logic [pfc_pkg::PixelWidth-1:0] px);
      pfc_pkg::rgb_type               c;
      logic [17:0]                    sum;
      logic [pfc_pkg::PixelWidth-1:0] res;
      res = '0;
      case (action)
         pfc_pkg::ACT_RGB48_TO_RAW:
            res = pack_rgb(fmt, px[47:32], px[31:16], px[15:0], 1'b0);
         pfc_pkg::ACT_RAW_TO_RGB48:  res = unpack_raw(fmt, px);
         pfc_pkg::ACT_GREY16_TO_RAW:
            res = pack_rgb(fmt, px[15:0], px[15:0], px[15:0], 1'b1);
         pfc_pkg::ACT_RAW_TO_GREY16: begin
            if (fmt == pfc_pkg::FMT_EPAPER) begin
               if (px[0]) res = '0;
               else if (px[1]) res = {32'd0, pfc_pkg::EPD_RED_GREY16};
               else res = {32'd0, 16'hffff};
            end else begin
               c   = unpack_raw(fmt, px);
               sum = {2'b00, c.r} + {2'b00, c.g} + {2'b00, c.b};
               res = {32'd0, 16'(sum / 3)};
            end
         end
         pfc_pkg::ACT_RGB24_TO_RAW:
            res = pack_rgb(fmt, {2{px[23:16]}}, {2{px[15:8]}}, {2{px[7:0]}}, 1'b0);
         pfc_pkg::ACT_RAW_TO_RGB24: begin
            c   = unpack_raw(fmt, px);
            res = {24'd0, c.r[15:8], c.g[15:8], c.b[15:8]};
         end
         default: res = '0;
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus

   task automatic add_pixel(logic [2:0] action, logic [pfc_pkg::PixelWidth-1:0] px, int gap);
      pixel_job_type j;
      j        = '0;
      j.action = action;
      j.pixel  = px;
      j.gap    = 4'(gap);
      job_q.push_back(j);
   endtask

   task automatic add_format(logic [3:0] fmt);
      pixel_job_type j;
      j        = '0;
      j.is_cfg = 1'b1;
      j.fmt    = fmt;
      job_q.push_back(j);
   endtask

   function automatic logic [15:0] random_channel();
      logic [15:0] c;
      case ($urandom_range(0, 7))
         0:       c = 16'h0000;
         1:       c = 16'hffff;
         2:       c = 16'(16'h00fe + $urandom_range(0, 3));
         3:       c = 16'(16'h1ffe + $urandom_range(0, 3));
         4:       c = 16'(16'h7ffe + $urandom_range(0, 3));
         default: c = 16'($urandom);
      endcase
      return c;
   endfunction

   task automatic add_random_pixel(logic [3:0] fmt, logic quiet);
      logic [2:0]                     action;
      logic [pfc_pkg::PixelWidth-1:0] px;
      logic [pfc_pkg::PixelWidth-1:0] stray;
      logic [pfc_pkg::PixelWidth-1:0] mask;
      logic                           noisy;
      int                             raw_bits;
      if ($urandom_range(0, 15) == 0) action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
      else action = 3'($urandom_range(pfc_pkg::ACT_RGB48_TO_RAW, pfc_pkg::ACT_RAW_TO_RGB24));
      noisy = ($urandom_range(0, 3) == 0);
      stray = {16'($urandom), 32'($urandom)};
      case (fmt)
         pfc_pkg::FMT_EPAPER, pfc_pkg::FMT_GREY2:  raw_bits = 2;
         pfc_pkg::FMT_GREY1:                       raw_bits = 1;
         pfc_pkg::FMT_GREY4:                       raw_bits = 4;
         pfc_pkg::FMT_GREY8, pfc_pkg::FMT_RGB332:  raw_bits = 8;
         pfc_pkg::FMT_GREY16, pfc_pkg::FMT_RGB565: raw_bits = 16;
         pfc_pkg::FMT_RGB666:                      raw_bits = 18;
         pfc_pkg::FMT_RGB30:                       raw_bits = 30;
         pfc_pkg::FMT_RGB36:                       raw_bits = 36;
         pfc_pkg::FMT_RGB48:                       raw_bits = 48;
         default:                                  raw_bits = 24;
      endcase
      case (action)
         pfc_pkg::ACT_RGB48_TO_RAW:
            px = {random_channel(), random_channel(), random_channel()};
         pfc_pkg::ACT_GREY16_TO_RAW: begin
            px = {32'd0, random_channel()};
            if (noisy) px[47:16] = stray[47:16];
         end
         pfc_pkg::ACT_RGB24_TO_RAW: begin
            px = {random_channel() >> 8, random_channel() >> 8, random_channel() >> 8};
            px = {24'd0, px[39:32], px[23:16], px[7:0]};
            if (noisy) px[47:24] = stray[47:24];
         end
         default: begin
            mask = (raw_bits == 48) ? '1 : ((48'd1 << raw_bits) - 48'd1);
            case ($urandom_range(0, 5))
               0:       px = '0;
               1:       px = '1;
               default: px = stray;
            endcase
            if (!noisy) px = px & mask;
         end
      endcase
      add_pixel(action, px, quiet ? 0 : $urandom_range(0, 9));
   endtask

   // ---------------------------------------------------------------- driver

   always @(negedge clock) begin
      if (reset) begin
         start  <= 1'b0;
         csr_we <= 1'b0;
      end else begin
         drv_start = 1'b0;
         drv_we    = 1'b0;
         if (in_flight && n_accepted == n_issued) in_flight = 1'b0;
         if (in_flight) begin
            drv_start = 1'b1;
         end else begin
            if (!have_job && job_q.size() > 0) begin
               cur_job  = job_q.pop_front();
               have_job = 1'b1;
            end
            if (have_job) begin
               if (cur_job.gap != 0) begin
                  cur_job.gap = cur_job.gap - 4'd1;
               end else if (cur_job.is_cfg) begin
                  if (expected_pixels.size() == 0) begin
                     csr_wdata <= cur_job.fmt;
                     drv_we    = 1'b1;
                     have_job  = 1'b0;
                  end
               end else begin
                  req_action   <= cur_job.action;
                  req_pixel_in <= cur_job.pixel;
                  drv_start    = 1'b1;
                  in_flight    = 1'b1;
                  have_job     = 1'b0;
                  n_issued++;
               end
            end
         end
         start  <= drv_start;
         csr_we <= drv_we;
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      logic [pfc_pkg::PixelWidth-1:0] exp_px;
      if (reset) begin
         fmt_model = pfc_pkg::FMT_RGB888;
      end else begin
         if (rsp_valid) begin
            if (expected_pixels.size() == 0) begin
               $error("pixel_out: expected no transaction, actual %h", rsp_pixel_out);
               n_errors++;
            end else begin
               exp_px = expected_pixels.pop_front();
               if (rsp_pixel_out !== exp_px) begin
                  $error("pixel_out: expected %h, actual %h", exp_px, rsp_pixel_out);
                  n_errors++;
               end
               n_checked++;
            end
         end
         if (start && !busy) begin
            expected_pixels.push_back(convert_pixel(fmt_model, req_action, req_pixel_in));
            n_accepted++;
         end
         if (csr_we) begin
            fmt_model = csr_wdata;
            n_fmt_writes++;
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      logic [3:0] fmt;
      logic       quiet;

      // default format after reset
      add_pixel(pfc_pkg::ACT_RGB48_TO_RAW, 48'hffff_ffff_ffff, 0);
      add_pixel(pfc_pkg::ACT_RAW_TO_RGB48, 48'h0000_00ff_ffff, 1);

      // e-paper thresholds
      add_format(pfc_pkg::FMT_EPAPER);
      add_pixel(pfc_pkg::ACT_GREY16_TO_RAW, 48'h1fff, 0);
      add_pixel(pfc_pkg::ACT_GREY16_TO_RAW, 48'h2000, 0);
      add_pixel(pfc_pkg::ACT_GREY16_TO_RAW, 48'h7fff, 2);
      add_pixel(pfc_pkg::ACT_GREY16_TO_RAW, 48'h8000, 0);
      add_pixel(pfc_pkg::ACT_GREY16_TO_RAW, 48'hffff, 0);
      add_pixel(pfc_pkg::ACT_RGB48_TO_RAW, 48'h00ff_00ff_00ff, 3);
      add_pixel(pfc_pkg::ACT_RGB48_TO_RAW, 48'h0100_0100_0100, 0);
      add_pixel(pfc_pkg::ACT_RGB48_TO_RAW, 48'h0400_0100_0100, 0);
      add_pixel(pfc_pkg::ACT_RAW_TO_GREY16, 48'h0, 0);
      add_pixel(pfc_pkg::ACT_RAW_TO_GREY16, 48'h1, 1);
      add_pixel(pfc_pkg::ACT_RAW_TO_GREY16, 48'h2, 0);
      add_pixel(pfc_pkg::ACT_RAW_TO_GREY16, 48'h3, 0);
      add_pixel(pfc_pkg::ACT_RAW_TO_RGB48, 48'hffff_ffff_fffe, 0);

      add_format(pfc_pkg::FMT_RGB48);
      add_pixel(pfc_pkg::ACT_RAW_TO_RGB48, 48'hffff_ffff_ffff, 0);
      add_pixel(pfc_pkg::ACT_RGB48_TO_RAW, 48'h1234_5678_9abc, 0);

      // spare format codes fall back to RGB888, spare actions give zero
      add_format(FMT_SPARE_HI);
      add_pixel(pfc_pkg::ACT_RAW_TO_RGB24, 48'hffff_ff00_0012, 0);
      add_pixel(pfc_pkg::ACT_RGB24_TO_RAW, 48'hffff_ffff_ffff, 4);
      add_pixel(ACT_SPARE_LO, 48'hffff_ffff_ffff, 0);
      add_pixel(ACT_SPARE_HI, 48'hffff_ffff_ffff, 0);

      // stray bits above the field width
      add_format(pfc_pkg::FMT_GREY2);
      add_pixel(pfc_pkg::ACT_RAW_TO_GREY16, 48'hffff_ffff_fffe, 0);
      add_pixel(pfc_pkg::ACT_GREY16_TO_RAW, 48'hffff_0000_c000, 0);

      add_format(pfc_pkg::FMT_RGB565);
      add_pixel(pfc_pkg::ACT_RAW_TO_RGB48, 48'h0000_0000_001f, 0);

      for (int p = 0; p < PHASES; p++) begin
         fmt   = (p < 16) ? 4'(p) : 4'($urandom_range(0, 15));
         quiet = ($urandom_range(0, 2) == 0);
         add_format(fmt);
         for (int i = 0; i < PHASE_PIXELS; i++) add_random_pixel(fmt, quiet);
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (job_q.size() > 0 || have_job || in_flight || expected_pixels.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Converted %0d pixels (%0d checked) across %0d pixel format writes.",
               n_accepted, n_checked, n_fmt_writes);
      $display("All formats, actions, spare codes and stray input bits were exercised.");
      if (n_errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d transactions outstanding.", expected_pixels.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
